// File: rtl/tcw_pkg.sv
package tcw_pkg;

    localparam int DEF_COLUMNS   = 80;
    localparam int DEF_ROWS      = 25;
    localparam int DEF_TAB_WIDTH = 8;

    localparam int CELL_W = 16;

    localparam logic [7:0] RESET_ATTR = 8'h0F;
    localparam logic [7:0] BLANK_CHAR = 8'h20;
    localparam logic [7:0] PRINT_LO   = 8'h20;
    localparam logic [7:0] PRINT_HI   = 8'h7F;

    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;

    localparam logic ACT_PUT  = 1'b0;
    localparam logic ACT_READ = 1'b1;

    // Packed so that cursor_col sits in the lowest bits.
    typedef struct packed {
        logic [15:0] read_data;
        logic        scrolled;
        logic [10:0] cursor_location;
        logic [4:0]  cursor_row;
        logic [6:0]  cursor_col;
    } tcw_result_t;

endpackage

// File: rtl/tcw_fb_mem.sv
module tcw_fb_mem
    import tcw_pkg::*;
#(
    parameter int DEPTH = DEF_ROWS * DEF_COLUMNS,
    localparam int ADDR_W = $clog2(DEPTH)
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [CELL_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [CELL_W-1:0] rdata
);

    logic [CELL_W-1:0] mem [DEPTH];
    logic [CELL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/tcw_ctrl.sv
module tcw_ctrl
    import tcw_pkg::*;
#(
    parameter int COLUMNS   = DEF_COLUMNS,
    parameter int ROWS      = DEF_ROWS,
    parameter int TAB_WIDTH = DEF_TAB_WIDTH,
    localparam int ADDR_W   = $clog2(ROWS * COLUMNS)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic              action,
    input  logic [7:0]        char_code,
    input  logic [10:0]       cell_index,
    input  logic              cfg_tvalid,
    input  logic [7:0]        cfg_tdata,
    input  logic              out_space,
    output logic              res_valid,
    output tcw_result_t       res,
    output logic              mem_we,
    output logic [ADDR_W-1:0] mem_waddr,
    output logic [CELL_W-1:0] mem_wdata,
    output logic              mem_re,
    output logic [ADDR_W-1:0] mem_raddr,
    input  logic [CELL_W-1:0] mem_rdata
);

    localparam int CELLS      = ROWS * COLUMNS;
    localparam int MOVE_CELLS = (ROWS - 1) * COLUMNS;
    localparam int COL_W      = $clog2(COLUMNS);
    localparam int NCOL_W     = $clog2(COLUMNS + TAB_WIDTH);
    localparam int ROW_W      = $clog2(ROWS);
    localparam int NROW_W     = $clog2(ROWS + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CLEAR = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_MOVE  = 3'd3;
    localparam logic [2:0] ST_FILL  = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [ADDR_W-1:0] scan_reg, scan_next;
    logic              pend_reg, pend_next;
    logic [ADDR_W-1:0] pend_addr_reg, pend_addr_next;
    logic              oor_reg, oor_next;
    logic [7:0]        attr_reg, attr_next;

    logic [NCOL_W-1:0] tab_stop [COLUMNS];
    logic [NCOL_W-1:0] ncol;
    logic [NROW_W-1:0] nrow;
    logic              printable;
    logic              need_scroll;
    logic [COL_W-1:0]  put_col;
    logic [ROW_W-1:0]  put_row;
    logic              accept;
    logic [COL_W-1:0]  sel_col;
    logic [ROW_W-1:0]  sel_row;
    logic [31:0]       col_wide;
    logic [31:0]       row_wide;
    logic [31:0]       loc_wide;
    logic              res_scrolled;
    logic [CELL_W-1:0] res_data;

    for (genvar g = 0; g < COLUMNS; g++)
    begin : g_tab
        localparam int STOP = (g / TAB_WIDTH + 1) * TAB_WIDTH;
        assign tab_stop[g] = NCOL_W'(STOP);
    end

    assign s_tready = (state_reg == ST_IDLE) && out_space;
    assign accept   = s_tvalid && s_tready;

    // Cursor update for one put byte, including the wrap and scroll checks.
    always_comb
    begin
        ncol      = NCOL_W'(col_reg);
        nrow      = NROW_W'(row_reg);
        printable = 1'b0;
        unique case (char_code)
            CH_BS:
            begin
                if (col_reg != '0)
                begin
                    ncol = ncol - NCOL_W'(1);
                end
            end
            CH_TAB:
            begin
                ncol = tab_stop[col_reg];
            end
            CH_CR:
            begin
                ncol = '0;
            end
            CH_LF:
            begin
                ncol = '0;
                nrow = nrow + NROW_W'(1);
            end
            default:
            begin
                if (char_code >= PRINT_LO && char_code <= PRINT_HI)
                begin
                    printable = 1'b1;
                    ncol      = ncol + NCOL_W'(1);
                end
            end
        endcase
        if (32'(ncol) >= COLUMNS)
        begin
            ncol = '0;
            nrow = nrow + NROW_W'(1);
        end
        need_scroll = (32'(nrow) >= ROWS);
        if (need_scroll)
        begin
            nrow = NROW_W'(ROWS - 1);
        end
        put_col = COL_W'(ncol);
        put_row = ROW_W'(nrow);
    end

    always_comb
    begin
        state_next     = state_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        scan_next      = scan_reg;
        pend_next      = (state_reg == ST_MOVE);
        pend_addr_next = pend_addr_reg;
        oor_next       = oor_reg;
        attr_next      = cfg_tvalid ? cfg_tdata : attr_reg;

        mem_we       = 1'b0;
        mem_waddr    = scan_reg;
        mem_wdata    = {attr_reg, BLANK_CHAR};
        mem_re       = 1'b0;
        mem_raddr    = scan_reg + ADDR_W'(COLUMNS);
        res_valid    = 1'b0;
        res_scrolled = 1'b0;
        res_data     = '0;
        sel_col      = col_reg;
        sel_row      = row_reg;

        // A moved cell is written in the cycle after its read was issued.
        if (pend_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = pend_addr_reg;
            mem_wdata = mem_rdata;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_wdata = {RESET_ATTR, BLANK_CHAR};
                if (scan_reg == ADDR_W'(CELLS - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    scan_next = scan_reg + ADDR_W'(1);
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (action == ACT_READ)
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = ADDR_W'(cell_index);
                        oor_next   = (32'(cell_index) >= CELLS);
                        state_next = ST_READ;
                    end
                    else
                    begin
                        if (printable)
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = ADDR_W'(32'(row_reg) * COLUMNS + 32'(col_reg));
                            mem_wdata = {attr_reg, char_code};
                        end
                        col_next = put_col;
                        row_next = put_row;
                        if (need_scroll)
                        begin
                            scan_next  = '0;
                            state_next = ST_MOVE;
                        end
                        else
                        begin
                            res_valid = 1'b1;
                            sel_col   = put_col;
                            sel_row   = put_row;
                        end
                    end
                end
            end
            ST_READ:
            begin
                res_valid  = 1'b1;
                res_data   = oor_reg ? '0 : mem_rdata;
                state_next = ST_IDLE;
            end
            ST_MOVE:
            begin
                mem_re         = 1'b1;
                pend_addr_next = scan_reg;
                if (scan_reg == ADDR_W'(MOVE_CELLS - 1))
                begin
                    scan_next  = ADDR_W'(MOVE_CELLS);
                    state_next = ST_FILL;
                end
                else
                begin
                    scan_next = scan_reg + ADDR_W'(1);
                end
            end
            ST_FILL:
            begin
                if (!pend_reg)
                begin
                    mem_we = 1'b1;
                    if (scan_reg == ADDR_W'(CELLS - 1))
                    begin
                        res_valid    = 1'b1;
                        res_scrolled = 1'b1;
                        state_next   = ST_IDLE;
                    end
                    else
                    begin
                        scan_next = scan_reg + ADDR_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        col_wide = 32'(sel_col);
        row_wide = 32'(sel_row);
        loc_wide = row_wide * COLUMNS + col_wide;
        res.cursor_col      = col_wide[6:0];
        res.cursor_row      = row_wide[4:0];
        res.cursor_location = loc_wide[10:0];
        res.scrolled        = res_scrolled;
        res.read_data       = res_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            col_reg   <= '0;
            row_reg   <= '0;
            scan_reg  <= '0;
            pend_reg  <= 1'b0;
            oor_reg   <= 1'b0;
            attr_reg  <= RESET_ATTR;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            scan_reg  <= scan_next;
            pend_reg  <= pend_next;
            oor_reg   <= oor_next;
            attr_reg  <= attr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_addr_reg <= pend_addr_next;
    end

endmodule

// File: rtl/text_console_writer.sv
// Text console writer: keeps a ROWS x COLUMNS framebuffer of 16-bit cells
// (attribute in the high byte, character in the low byte) in one block RAM
// and returns exactly one result word per input word. After reset the RAM is
// swept to blanks one cell per cycle, and s_tready stays low until that is
// done; text_attribute may be written meanwhile. A put that does not scroll
// gives its result in the cycle it is accepted, and a cell read gives it from
// the read state, since the RAM read data is registered. A put that scrolls
// moves the lower ROWS-1 rows up through the single RAM write port, one cell
// per cycle, and then blanks the bottom row. The next word is taken only once
// the current one has its result; a two-word output buffer lets input
// continue while earlier results wait.
module text_console_writer
    import tcw_pkg::*;
#(
    parameter int COLUMNS   = DEF_COLUMNS,
    parameter int ROWS      = DEF_ROWS,
    parameter int TAB_WIDTH = DEF_TAB_WIDTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // char_code[7:0], cell_index[18:8]
    input  logic        s_tuser,    // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // cursor_col[6:0], cursor_row[11:7],
                                    // cursor_location[22:12], scrolled[23],
                                    // read_data[39:24]
    input  logic        cfg_tvalid,
    output logic        cfg_tready,
    input  logic [7:0]  cfg_tdata   // text_attribute
);

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int ADDR_W = $clog2(CELLS);

    logic              out_space;
    logic              res_valid;
    tcw_result_t       res;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic [CELL_W-1:0] mem_rdata;

    tcw_result_t       buf_reg [2];
    logic [1:0]        cnt_reg, cnt_next;
    logic [1:0]        cnt_after_pop;
    logic              pop;

    assign cfg_tready = 1'b1;

    tcw_ctrl #(
        .COLUMNS   (COLUMNS),
        .ROWS      (ROWS),
        .TAB_WIDTH (TAB_WIDTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .action     (s_tuser),
        .char_code  (s_tdata[7:0]),
        .cell_index (s_tdata[18:8]),
        .cfg_tvalid (cfg_tvalid),
        .cfg_tdata  (cfg_tdata),
        .out_space  (out_space),
        .res_valid  (res_valid),
        .res        (res),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_re     (mem_re),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata)
    );

    tcw_fb_mem #(
        .DEPTH (CELLS)
    ) u_fb_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Two-word output buffer; a word may be accepted while one result waits.
    assign m_tvalid  = (cnt_reg != 2'd0);
    assign m_tdata   = buf_reg[0];
    assign pop       = m_tvalid && m_tready;
    assign out_space = (cnt_reg != 2'd2) || m_tready;

    always_comb
    begin
        cnt_after_pop = cnt_reg - 2'(pop);
        cnt_next      = cnt_after_pop + 2'(res_valid);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && cnt_after_pop == 2'd0)
        begin
            buf_reg[0] <= res;
        end
        else if (pop)
        begin
            buf_reg[0] <= buf_reg[1];
        end
        if (res_valid && cnt_after_pop == 2'd1)
        begin
            buf_reg[1] <= res;
        end
    end

    // A result must never arrive while the buffer is full and not draining.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && cnt_reg == 2'd2) |-> m_tready)
        else $error("output buffer overflow");

    // The cursor column handed out is always inside the screen.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (32'(res.cursor_col) < COLUMNS))
        else $error("cursor column out of range");

    // A scrolling put always leaves the cursor on the bottom row.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.scrolled) |-> (32'(res.cursor_row) == ((ROWS - 1) & 31)))
        else $error("scroll left cursor off the bottom row");

endmodule

// File: dv/tcw_screen_checker.sv
module tcw_screen_checker
    import tcw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,    // char_code[7:0], cell_index[18:8]
    input  logic        s_tuser,    // action
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,    // cursor_col, cursor_row, cursor_location,
                                    // scrolled, read_data
    input  logic        cfg_tvalid,
    input  logic        cfg_tready,
    input  logic [7:0]  cfg_tdata,  // text_attribute
    output int          fails,
    output int          owed,
    output int          scrolls
);

    localparam int COLS  = DEF_COLUMNS;
    localparam int LINES = DEF_ROWS;
    localparam int TABS  = DEF_TAB_WIDTH;
    localparam int CELLS = COLS * LINES;

    logic [15:0] screen [CELLS];
    logic [7:0]  attr;
    int          col;
    int          row;
    int          words_seen;
    tcw_result_t cursor_q [$];
    tcw_result_t next_word;

    task automatic report(input string msg);
        $display("tcw check: %s", msg);
        fails++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report($sformatf("word %0d: %s is 0x%0h, expected 0x%0h",
                             words_seen, name, got, want));
    endtask

    task automatic clear_screen();
        attr = RESET_ATTR;
        col  = 0;
        row  = 0;
        foreach (screen[k])
            screen[k] = {RESET_ATTR, BLANK_CHAR};
        cursor_q.delete();
    endtask

    task automatic put_byte(input logic [7:0] ch, output logic rolled);
        rolled = 1'b0;
        if (ch == CH_BS && col != 0)
            col--;
        else if (ch == CH_TAB)
            col = (col / TABS + 1) * TABS;
        else if (ch == CH_CR)
            col = 0;
        else if (ch == CH_LF)
        begin
            col = 0;
            row++;
        end
        else if (ch >= PRINT_LO && ch <= PRINT_HI)
        begin
            screen[row * COLS + col] = {attr, ch};
            col++;
        end
        if (col >= COLS)
        begin
            col = 0;
            row++;
        end
        // Running off the bottom moves every row up and blanks the last one
        // in the attribute in force now, not the one the text was written in.
        if (row >= LINES)
        begin
            for (int k = 0; k < CELLS - COLS; k++)
                screen[k] = screen[k + COLS];
            for (int k = CELLS - COLS; k < CELLS; k++)
                screen[k] = {attr, BLANK_CHAR};
            row    = LINES - 1;
            rolled = 1'b1;
        end
    endtask

    task automatic predict(input logic act, input logic [7:0] ch, input logic [10:0] pos,
                           output tcw_result_t r);
        logic        rolled;
        logic [15:0] data;
        rolled = 1'b0;
        data   = '0;
        if (act == ACT_PUT)
            put_byte(ch, rolled);
        else if (pos < CELLS)
            data = screen[pos];
        if (rolled)
            scrolls++;
        r.cursor_col      = 7'(col);
        r.cursor_row      = 5'(row);
        r.cursor_location = 11'(row * COLS + col);
        r.scrolled        = rolled;
        r.read_data       = data;
    endtask

    task automatic compare(input tcw_result_t got);
        tcw_result_t want;
        if (cursor_q.size() == 0)
        begin
            report($sformatf("word %0d arrived with nothing expected", words_seen));
            words_seen++;
            return;
        end
        want = cursor_q.pop_front();
        check_field("cursor_col", got.cursor_col, want.cursor_col);
        check_field("cursor_row", got.cursor_row, want.cursor_row);
        check_field("cursor_location", got.cursor_location, want.cursor_location);
        check_field("scrolled", got.scrolled, want.scrolled);
        check_field("read_data", got.read_data, want.read_data);
        words_seen++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_screen();
            owed <= 0;
        end
        else
        begin
            if (cfg_tvalid && cfg_tready)
                attr = cfg_tdata;
            if (m_tvalid && m_tready)
                compare(tcw_result_t'(m_tdata));
            if (s_tvalid && s_tready)
            begin
                predict(s_tuser, s_tdata[7:0], s_tdata[18:8], next_word);
                cursor_q.push_back(next_word);
            end
            owed <= cursor_q.size();
        end
    end

endmodule

// File: dv/tb_top.sv
module tb_top;
    import tcw_pkg::*;

    localparam int CELLS = DEF_COLUMNS * DEF_ROWS;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;      // char_code[7:0], cell_index[18:8]
    logic        s_tuser;      // action
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;      // cursor_col[6:0], cursor_row[11:7],
                               // cursor_location[22:12], scrolled[23],
                               // read_data[39:24]
    logic        cfg_tvalid;
    logic        cfg_tready;
    logic [7:0]  cfg_tdata;    // text_attribute

    int          fails;
    int          owed;
    int          scrolls;
    int          ready_hold;
    int          n_puts;
    int          n_reads;
    int          n_attrs;
    bit          steady;
    logic [7:0]  attr_plan [5];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    text_console_writer uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_tvalid (cfg_tvalid),
        .cfg_tready (cfg_tready),
        .cfg_tdata  (cfg_tdata)
    );

    tcw_screen_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_tvalid (cfg_tvalid),
        .cfg_tready (cfg_tready),
        .cfg_tdata  (cfg_tdata),
        .fails      (fails),
        .owed       (owed),
        .scrolls    (scrolls)
    );

    // After each result word the receiver holds off m_tready at random, except in steady mode.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            ready_hold = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                ready_hold = steady ? 0 : $urandom_range(0, 6);
            if (ready_hold > 0)
            begin
                m_tready <= 1'b0;
                ready_hold--;
            end
            else
                m_tready <= 1'b1;
        end
    end

    task automatic send_word(input logic act, input logic [7:0] ch, input logic [10:0] addr);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {5'd0, addr, ch};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (act == ACT_PUT)
            n_puts++;
        else
            n_reads++;
    endtask

    task automatic put_char(input logic [7:0] ch);
        send_word(ACT_PUT, ch, 11'($urandom_range(0, 2047)));
    endtask

    task automatic read_cell(input logic [10:0] addr);
        send_word(ACT_READ, 8'($urandom_range(0, 255)), addr);
    endtask

    // The checker's count is registered and lags the handshakes, hence the first edge.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (owed != 0)
            @(posedge clk);
    endtask

    task automatic set_attribute(input logic [7:0] value);
        wait_idle();
        cfg_tvalid <= 1'b1;
        cfg_tdata  <= value;
        @(posedge clk);
        while (!cfg_tready)
            @(posedge clk);
        cfg_tvalid <= 1'b0;
        n_attrs++;
    endtask

    task automatic random_word();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            read_cell(11'($urandom_range(0, 2047)));
        else if (pick < 20)
            read_cell(11'($urandom_range(0, CELLS - 1)));
        else if (pick < 76)
            put_char(8'($urandom_range(PRINT_LO, PRINT_HI)));
        else if (pick < 84)
            put_char(CH_LF);
        else if (pick < 88)
            put_char(CH_TAB);
        else if (pick < 91)
            put_char(CH_CR);
        else if (pick < 95)
            put_char(CH_BS);
        else
            put_char(8'($urandom_range(0, 255)));
    endtask

    initial
    begin
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = ACT_PUT;
        cfg_tvalid = 1'b0;
        cfg_tdata  = '0;
        steady     = 1'b0;
        attr_plan  = '{8'h00, 8'hFF, 8'h1E, 8'($urandom_range(0, 255)), RESET_ATTR};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed opening in the reset attribute; the first reads see what was just put.
        put_char(CH_BS);
        put_char(PRINT_LO);
        put_char(PRINT_HI);
        put_char(8'h41);
        put_char(CH_BS);
        put_char(CH_TAB);
        put_char(CH_TAB);
        put_char(CH_CR);
        put_char(CH_LF);
        put_char(8'h00);
        put_char(8'h1F);
        put_char(8'h80);
        put_char(8'hFF);
        put_char(8'h0B);
        read_cell(11'd0);
        read_cell(11'd1);
        read_cell(11'd2);
        read_cell(11'(CELLS - 1));
        read_cell(11'(CELLS));
        read_cell(11'd2047);

        foreach (attr_plan[p])
        begin
            set_attribute(attr_plan[p]);
            for (int k = 0; k < 150; k++)
            begin
                if (k % 40 == 0)
                    steady <= ($urandom_range(0, 3) == 0);
                random_word();
            end
        end

        wait_idle();
        repeat (50) @(posedge clk);

        $display("Covered %0d words: %0d puts and %0d reads under %0d attribute settings.",
                 n_puts + n_reads, n_puts, n_reads, n_attrs + 1);
        $display("The screen scrolled %0d times along the way.", scrolls);
        if (fails == 0 && owed == 0)
            $display("text_console_writer: match");
        else
            $display("text_console_writer: mismatch");
        $finish;
    end

    initial
    begin
        #100_000_000;
        $display("Run stopped by the time limit with %0d words still owed.", owed);
        $display("text_console_writer: mismatch");
        $finish;
    end

endmodule

// File: text_console_writer.f
rtl/tcw_pkg.sv
rtl/tcw_fb_mem.sv
rtl/tcw_ctrl.sv
rtl/text_console_writer.sv
dv/tcw_screen_checker.sv
dv/tb_top.sv
